@@ rtl/gpd_pkg.sv @@
// ============================================================================
// gpd_pkg - shared definitions for the GF(2^8) polynomial divider
// Result kinds, size defaults and the field multiply used by the datapath.
// ============================================================================
package gpd_pkg;

    // Default capacity of each coefficient store.
    localparam int MAX_COEFFS_DEF = 32;

    // Reset value of the reduction polynomial's low byte.
    localparam logic [7:0] FIELD_POLY_RST = 8'd27;

    // Input command carried in tuser.
    localparam logic CMD_DIVISOR  = 1'b0;
    localparam logic CMD_DIVIDEND = 1'b1;

    // Result kind carried in tuser.
    localparam logic [1:0] KIND_QUOTIENT  = 2'd0;
    localparam logic [1:0] KIND_REMAINDER = 2'd1;
    localparam logic [1:0] KIND_DIV_ZERO  = 2'd2;

    // Shift-and-add multiply, reducing by x^8 plus the given low byte.
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b,
                                          input logic [7:0] poly);
        logic [7:0] x;
        logic [7:0] acc;
        x   = a;
        acc = 8'd0;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) begin
                acc = acc ^ x;
            end
            if (x[7]) begin
                x = {x[6:0], 1'b0} ^ poly;
            end else begin
                x = {x[6:0], 1'b0};
            end
        end
        return acc;
    endfunction

endpackage

@@ rtl/gf256_poly_divide_top.sv @@
// ============================================================================
// gf256_poly_divide_top - polynomial long division over GF(2^8)
// Loads a divisor and a dividend word by word, divides, streams the results.
// ============================================================================
//
// Input stream (s_*): one coefficient per word, lowest degree first.
// s_tuser[0] selects divisor (0) or dividend (1); s_tlast marks the final
// coefficient of a polynomial. Loading takes one cycle per word. A complete
// divisor stays in place for every later dividend until a new one starts.
// The final dividend word starts the division and s_tready drops until the
// last result word has been handed to the output register.
// Output stream (m_*): quotient words, then remainder words, lowest degree
// first; m_tuser gives the kind and m_tlast marks the final word. A zero
// divisor gives one error word instead.
// After the final dividend word come a decision step, a read of the divisor's
// leading coefficient, eight square-and-multiply steps and a read of the top
// work coefficient. Each quotient step then forms one quotient coefficient,
// makes a read-modify-write pass over the work memory at one coefficient per
// cycle under the trimmed divisor's lower terms and clears the top coefficient.
// The remainder trim reads and checks each trailing zero in turn, and each
// result word takes an address state and a load state, limited by the
// registered memory read. A stalled receiver holds the output register and
// the sequencer waits on it; input is not taken meanwhile.
// Reset (aresetn low at a clock edge) empties both polynomials, returns to
// the divisor phase and restores field_poly to 27. The config channel
// (cfg_*) is always ready; the user must write it only while the block is
// idle, since the block itself does not enforce this.
module gf256_poly_divide_top #(
    parameter int MAX_COEFFS = gpd_pkg::MAX_COEFFS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    // Configuration: field_poly, the low byte of the reduction polynomial.
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,
    // Input stream.
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] coefficient
    input  logic [0:0] s_tuser,   // [0] command
    input  logic       s_tlast,   // last
    // Result stream.
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] coefficient_res
    output logic [1:0] m_tuser,   // [1:0] kind
    output logic       m_tlast    // last_res
);

    localparam int ADDR_W = $clog2(MAX_COEFFS);
    localparam int LEN_W  = $clog2(MAX_COEFFS + 1);
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_COEFFS);

    // Sequencer states, one-hot.
    typedef enum logic [15:0] {
        S_IDLE  = 16'h0001,  // loading coefficients
        S_START = 16'h0002,  // decide error, divide or remainder only
        S_LEAD  = 16'h0004,  // read divisor leading coefficient
        S_LEADW = 16'h0008,  // capture it for inversion
        S_INV   = 16'h0010,  // square-and-multiply to lead^254
        S_TREAD = 16'h0020,  // read top work coefficient
        S_TMUL  = 16'h0040,  // quotient term, start divisor sweep
        S_UPD   = 16'h0080,  // work[sh+j] ^= t * divisor[j]
        S_ZERO  = 16'h0100,  // clear top coefficient, read the next one
        S_RSCAN = 16'h0200,  // remainder trim: read candidate top
        S_RCHK  = 16'h0400,  // remainder trim: check it
        S_QRD   = 16'h0800,  // quotient output: address
        S_QOUT  = 16'h1000,  // quotient output: load word
        S_RRD   = 16'h2000,  // remainder output: address
        S_ROUT  = 16'h4000,  // remainder output: load word
        S_ERR   = 16'h8000   // division by zero word
    } state_t;

    state_t state_reg, state_next;

    logic [7:0]        field_poly_reg;
    logic [LEN_W-1:0]  div_len_reg, div_len_next;
    logic [LEN_W-1:0]  div_nz_reg, div_nz_next;
    logic [LEN_W-1:0]  work_len_reg, work_len_next;
    logic [LEN_W-1:0]  work_nz_reg, work_nz_next;
    logic              load_phase_reg, load_phase_next;
    logic [LEN_W-1:0]  nd_reg, nd_next;
    logic [LEN_W-1:0]  nw_reg, nw_next;
    logic [LEN_W-1:0]  qn_reg, qn_next;
    logic [LEN_W-1:0]  rn_reg, rn_next;
    logic [LEN_W-1:0]  idx_reg, idx_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic [ADDR_W-1:0] j_reg, j_next;
    logic [7:0]        t_reg, t_next;
    logic [7:0]        base_reg, base_next;
    logic [7:0]        inv_reg, inv_next;
    logic [2:0]        k_reg, k_next;

    logic              out_valid_reg, out_valid_next;
    logic [1:0]        out_kind_reg, out_kind_next;
    logic [7:0]        out_coef_reg, out_coef_next;
    logic              out_last_reg, out_last_next;

    // Memory ports.
    logic              div_we, work_we, quo_we;
    logic [ADDR_W-1:0] div_waddr, div_raddr, work_waddr, work_raddr, quo_waddr, quo_raddr;
    logic [7:0]        div_wdata, work_wdata, quo_wdata;
    logic [7:0]        div_rdata, work_rdata, quo_rdata;

    gpd_ram #(.WIDTH(8), .DEPTH(MAX_COEFFS)) u_div_ram (
        .aclk(aclk), .we(div_we), .waddr(div_waddr), .wdata(div_wdata),
        .raddr(div_raddr), .rdata(div_rdata)
    );

    gpd_ram #(.WIDTH(8), .DEPTH(MAX_COEFFS)) u_work_ram (
        .aclk(aclk), .we(work_we), .waddr(work_waddr), .wdata(work_wdata),
        .raddr(work_raddr), .rdata(work_rdata)
    );

    gpd_ram #(.WIDTH(8), .DEPTH(MAX_COEFFS)) u_quo_ram (
        .aclk(aclk), .we(quo_we), .waddr(quo_waddr), .wdata(quo_wdata),
        .raddr(quo_raddr), .rdata(quo_rdata)
    );

    // Derived indexes. The shift sh is the quotient degree of the current step.
    logic [LEN_W-1:0]  nd_m1;
    logic [ADDR_W-1:0] sh;
    logic              s_accept;
    logic              out_free;
    logic [LEN_W-1:0]  div_idx;
    logic [7:0]        prod_upd, prod_t, prod_r, prod_b;

    assign nd_m1    = nd_reg - LEN_W'(1);
    assign sh       = pos_reg - nd_m1[ADDR_W-1:0];
    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign div_idx  = load_phase_reg ? '0 : div_len_reg;
    assign cfg_ready = 1'b1;

    assign prod_t   = gpd_pkg::gf_mul(work_rdata, inv_reg, field_poly_reg);
    assign prod_upd = gpd_pkg::gf_mul(t_reg, div_rdata, field_poly_reg);
    assign prod_r   = gpd_pkg::gf_mul(inv_reg, base_reg, field_poly_reg);
    assign prod_b   = gpd_pkg::gf_mul(base_reg, base_reg, field_poly_reg);

    always_comb begin
        state_next      = state_reg;
        div_len_next    = div_len_reg;
        div_nz_next     = div_nz_reg;
        work_len_next   = work_len_reg;
        work_nz_next    = work_nz_reg;
        load_phase_next = load_phase_reg;
        nd_next         = nd_reg;
        nw_next         = nw_reg;
        qn_next         = qn_reg;
        rn_next         = rn_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        j_next          = j_reg;
        t_next          = t_reg;
        base_next       = base_reg;
        inv_next        = inv_reg;
        k_next          = k_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_kind_next   = out_kind_reg;
        out_coef_next   = out_coef_reg;
        out_last_next   = out_last_reg;

        div_we     = 1'b0;
        div_waddr  = div_idx[ADDR_W-1:0];
        div_wdata  = s_tdata;
        div_raddr  = '0;
        work_we    = 1'b0;
        work_waddr = work_len_reg[ADDR_W-1:0];
        work_wdata = s_tdata;
        work_raddr = '0;
        quo_we     = 1'b0;
        quo_waddr  = sh;
        quo_wdata  = prod_t;
        quo_raddr  = idx_reg[ADDR_W-1:0];

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    if (s_tuser[0] == gpd_pkg::CMD_DIVISOR) begin
                        // A divisor word after a complete divisor starts a new one.
                        if (load_phase_reg) begin
                            div_nz_next = '0;
                        end
                        div_len_next = div_idx;
                        if (div_idx < MAX_LEN) begin
                            div_we       = 1'b1;
                            div_len_next = div_idx + LEN_W'(1);
                            if (s_tdata != 8'd0) begin
                                div_nz_next = div_idx + LEN_W'(1);
                            end
                        end
                        load_phase_next = s_tlast;
                    end else begin
                        nw_next = work_nz_reg;
                        if (work_len_reg < MAX_LEN) begin
                            work_we       = 1'b1;
                            work_len_next = work_len_reg + LEN_W'(1);
                            if (s_tdata != 8'd0) begin
                                work_nz_next = work_len_reg + LEN_W'(1);
                                nw_next      = work_len_reg + LEN_W'(1);
                            end
                        end
                        if (s_tlast) begin
                            nd_next       = div_nz_reg;
                            work_len_next = '0;
                            work_nz_next  = '0;
                            state_next    = S_START;
                        end
                    end
                end
            end
            S_START: begin
                qn_next  = '0;
                idx_next = '0;
                rn_next  = (nw_reg < nd_reg) ? nw_reg : nd_m1;
                if (nd_reg == '0) begin
                    state_next = S_ERR;
                end else if (nw_reg >= nd_reg) begin
                    state_next = S_LEAD;
                end else begin
                    state_next = S_RSCAN;
                end
            end
            S_LEAD: begin
                div_raddr  = nd_m1[ADDR_W-1:0];
                state_next = S_LEADW;
            end
            S_LEADW: begin
                base_next  = div_rdata;
                inv_next   = 8'd1;
                k_next     = '0;
                state_next = S_INV;
            end
            S_INV: begin
                // 254 has every exponent bit set except bit zero.
                if (k_reg != 3'd0) begin
                    inv_next = prod_r;
                end
                base_next = prod_b;
                k_next    = k_reg + 3'd1;
                if (k_reg == 3'd7) begin
                    pos_next   = ADDR_W'(nw_reg - LEN_W'(1));
                    state_next = S_TREAD;
                end
            end
            S_TREAD: begin
                work_raddr = pos_reg;
                state_next = S_TMUL;
            end
            S_TMUL: begin
                t_next = prod_t;
                quo_we = 1'b1;
                // Steps run from the highest degree down, so the first nonzero
                // term fixes the trimmed quotient length.
                if (prod_t != 8'd0 && qn_reg == '0) begin
                    qn_next = LEN_W'(sh) + LEN_W'(1);
                end
                div_raddr  = '0;
                work_raddr = sh;
                j_next     = '0;
                state_next = (nd_reg == LEN_W'(1)) ? S_ZERO : S_UPD;
            end
            S_UPD: begin
                work_we    = 1'b1;
                work_waddr = sh + j_reg;
                work_wdata = work_rdata ^ prod_upd;
                div_raddr  = j_reg + ADDR_W'(1);
                work_raddr = sh + j_reg + ADDR_W'(1);
                j_next     = j_reg + ADDR_W'(1);
                if (LEN_W'(j_reg) == nd_reg - LEN_W'(2)) begin
                    state_next = S_ZERO;
                end
            end
            S_ZERO: begin
                work_we    = 1'b1;
                work_waddr = pos_reg;
                work_wdata = 8'd0;
                work_raddr = pos_reg - ADDR_W'(1);
                if (LEN_W'(pos_reg) == nd_m1) begin
                    state_next = S_RSCAN;
                end else begin
                    pos_next   = pos_reg - ADDR_W'(1);
                    state_next = S_TMUL;
                end
            end
            S_RSCAN: begin
                work_raddr = ADDR_W'(rn_reg - LEN_W'(1));
                state_next = (rn_reg == '0) ? S_QRD : S_RCHK;
            end
            S_RCHK: begin
                work_raddr = ADDR_W'(rn_reg - LEN_W'(1));
                if (work_rdata == 8'd0) begin
                    rn_next    = rn_reg - LEN_W'(1);
                    state_next = S_RSCAN;
                end else begin
                    state_next = S_QRD;
                end
            end
            S_QRD: begin
                if (idx_reg == qn_reg) begin
                    idx_next   = '0;
                    state_next = S_RRD;
                end else begin
                    state_next = S_QOUT;
                end
            end
            S_QOUT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_kind_next  = gpd_pkg::KIND_QUOTIENT;
                    out_coef_next  = quo_rdata;
                    out_last_next  = 1'b0;
                    idx_next       = idx_reg + LEN_W'(1);
                    state_next     = S_QRD;
                end
            end
            S_RRD: begin
                work_raddr = idx_reg[ADDR_W-1:0];
                if (rn_reg == '0) begin
                    // Empty remainder is sent as a single zero.
                    if (out_free) begin
                        out_valid_next = 1'b1;
                        out_kind_next  = gpd_pkg::KIND_REMAINDER;
                        out_coef_next  = 8'd0;
                        out_last_next  = 1'b1;
                        state_next     = S_IDLE;
                    end
                end else begin
                    state_next = S_ROUT;
                end
            end
            S_ROUT: begin
                work_raddr = idx_reg[ADDR_W-1:0];
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_kind_next  = gpd_pkg::KIND_REMAINDER;
                    out_coef_next  = work_rdata;
                    out_last_next  = (idx_reg + LEN_W'(1) == rn_reg);
                    idx_next       = idx_reg + LEN_W'(1);
                    state_next     = (idx_reg + LEN_W'(1) == rn_reg) ? S_IDLE : S_RRD;
                end
            end
            S_ERR: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_kind_next  = gpd_pkg::KIND_DIV_ZERO;
                    out_coef_next  = 8'd0;
                    out_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            field_poly_reg <= gpd_pkg::FIELD_POLY_RST;
            div_len_reg    <= '0;
            div_nz_reg     <= '0;
            work_len_reg   <= '0;
            work_nz_reg    <= '0;
            load_phase_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            div_len_reg    <= div_len_next;
            div_nz_reg     <= div_nz_next;
            work_len_reg   <= work_len_next;
            work_nz_reg    <= work_nz_next;
            load_phase_reg <= load_phase_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                field_poly_reg <= cfg_data;
            end
        end
    end

    // Datapath registers; every one is set before it is used.
    always_ff @(posedge aclk) begin
        nd_reg       <= nd_next;
        nw_reg       <= nw_next;
        qn_reg       <= qn_next;
        rn_reg       <= rn_next;
        idx_reg      <= idx_next;
        pos_reg      <= pos_next;
        j_reg        <= j_next;
        t_reg        <= t_next;
        base_reg     <= base_next;
        inv_reg      <= inv_next;
        k_reg        <= k_next;
        out_kind_reg <= out_kind_next;
        out_coef_reg <= out_coef_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_coef_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

@@ rtl/gpd_ram.sv @@
// ============================================================================
// gpd_ram - simple dual-port RAM
// One write port and one read port, read data registered.
// ============================================================================
module gpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/gpd_checker.sv @@
// ============================================================================
// gpd_checker - port-level checks for the GF(2^8) polynomial divider
// Watches the result stream of the top level; attached by bind.
// ============================================================================
module gpd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser,
    input logic       m_tlast
);

    // A stalled result word holds still.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result word changed while stalled");

    // Only the three defined kinds appear.
    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == gpd_pkg::KIND_QUOTIENT) || (m_tuser == gpd_pkg::KIND_REMAINDER)
                     || (m_tuser == gpd_pkg::KIND_DIV_ZERO))
        else $error("undefined result kind");

    // The division-by-zero word is a lone zero that closes the division.
    a_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == gpd_pkg::KIND_DIV_ZERO) |-> m_tlast && (m_tdata == 8'd0))
        else $error("malformed division-by-zero word");

    // The remainder always follows the quotient, so a quotient word never ends it.
    a_quo: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == gpd_pkg::KIND_QUOTIENT) |-> !m_tlast)
        else $error("quotient word marked last");

endmodule

bind gf256_poly_divide_top gpd_checker u_gpd_checker (
    .aclk(aclk),
    .aresetn(aresetn),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
);

@@ test/tb_top.sv @@
// ============================================================================
// tb_top - self-checking bench for the GF(2^8) polynomial divider
// Streams divisor and dividend words into the block under random back pressure.
// A behavioral divider predicts quotient, remainder and error words, typed
// directed rows give theirs by hand, and each result word is compared field by
// field. Several field polynomials are exercised, the extremes included.
// ============================================================================
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COEFF_SLOTS    = gpd_pkg::MAX_COEFFS_DEF;
    localparam int WATCHDOG_LIMIT = 20000;  // cycles with no handshake at all
    localparam int SETTLE_CYCLES  = 40;     // drain time before a write or the end
    localparam int IDLE_PERCENT   = 18;
    localparam int PHASE_WORDS    = 20;     // minimum random input words per field polynomial
    localparam int DIRECTED_ROWS  = 25;
    localparam logic [7:0] INV_EXPONENT = 8'd254;

    // One result word as it leaves the block.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] coef;
        logic       last;
    } result_word_t;

    // One row of the directed table. When typed is set, the expected word is
    // written into the row and replaces the prediction for that input word.
    typedef struct packed {
        logic         cmd;
        logic [7:0]   coef;
        logic         last;
        logic         typed;
        result_word_t want;
    } stim_row_t;

    localparam result_word_t NO_WORD = '{gpd_pkg::KIND_QUOTIENT, 8'h00, 1'b0};

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data  = 8'h00;
    logic       s_tvalid  = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata   = 8'h00;  // [7:0] coefficient
    logic [0:0] s_tuser   = 1'b0;   // [0] command
    logic       s_tlast   = 1'b0;   // last
    logic       m_tvalid;
    logic       m_tready  = 1'b0;
    logic [7:0] m_tdata;            // [7:0] coefficient_res
    logic [1:0] m_tuser;            // [1:0] kind
    logic       m_tlast;            // last_res

    gf256_poly_divide_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // 8 ns clock.
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Behavioral divider: its own copy of the field polynomial, both loaded
    // polynomials and the phase flag.
    // ------------------------------------------------------------------------
    logic [7:0] poly_low;
    logic [7:0] divisor_coefs  [COEFF_SLOTS];
    logic [7:0] dividend_coefs [COEFF_SLOTS];
    logic [7:0] quotient_coefs [COEFF_SLOTS];
    int         divisor_count;
    int         dividend_count;
    logic       divisor_closed;

    result_word_t expected_words [$];  // predicted words not yet seen
    result_word_t step_words [$];      // words caused by the latest input word

    // Bench-side control and counters used by the stimulus, the monitor and the receiver.
    logic         typed_valid = 1'b0;
    result_word_t typed_word  = NO_WORD;
    logic         quiet       = 1'b0;  // no idling on either side while set
    int           words_sent  = 0;
    int           mismatches  = 0;
    int           idle_cycles = 0;

    // Appends a word at the tail of the words caused by the latest input word.
    function automatic void add_step_word(input result_word_t w);
        step_words.insert(step_words.size(), w);
    endfunction

    // Appends a word at the tail of the predicted words.
    function automatic void add_expected_word(input result_word_t w);
        expected_words.insert(expected_words.size(), w);
    endfunction

    // Multiply in GF(2)[x] modulo x^8 + poly, top bit of b first.
    function automatic logic [7:0] field_mul(input logic [7:0] a, input logic [7:0] b,
                                             input logic [7:0] poly);
        logic [7:0] acc;
        acc = 8'h00;
        for (int k = 7; k >= 0; k--) begin
            acc = {acc[6:0], 1'b0} ^ (acc[7] ? poly : 8'h00);
            if (b[k]) begin
                acc = acc ^ a;
            end
        end
        return acc;
    endfunction

    // b^254, the inverse in a true field. Used as is for reducible polynomials.
    function automatic logic [7:0] field_inv(input logic [7:0] b, input logic [7:0] poly);
        logic [7:0] r;
        r = 8'h01;
        for (int k = 7; k >= 0; k--) begin
            r = field_mul(r, r, poly);
            if (INV_EXPONENT[k]) begin
                r = field_mul(r, b, poly);
            end
        end
        return r;
    endfunction

    function automatic void divider_reset();
        poly_low       = gpd_pkg::FIELD_POLY_RST;
        divisor_count  = 0;
        dividend_count = 0;
        divisor_closed = 1'b0;
        for (int i = 0; i < COEFF_SLOTS; i++) begin
            quotient_coefs[i] = 8'h00;
        end
    endfunction

    // Advances the divider by one input word and leaves its output words in
    // step_words.
    function automatic void divide_step(input logic cmd, input logic [7:0] coef,
                                        input logic last);
        int         nd;
        int         nw;
        int         qn;
        int         rn;
        int         shift;
        logic [7:0] inv;
        logic [7:0] t;
        step_words.delete();
        if (cmd == gpd_pkg::CMD_DIVISOR) begin
            // A divisor word after a finished divisor begins a fresh one.
            if (divisor_closed) begin
                divisor_count  = 0;
                divisor_closed = 1'b0;
            end
            if (divisor_count < COEFF_SLOTS) begin
                divisor_coefs[divisor_count] = coef;
                divisor_count++;
            end
            if (last) begin
                divisor_closed = 1'b1;
            end
            return;
        end
        if (dividend_count < COEFF_SLOTS) begin
            dividend_coefs[dividend_count] = coef;
            dividend_count++;
        end
        if (!last) begin
            return;
        end
        nd = divisor_count;
        while (nd > 0 && divisor_coefs[nd - 1] == 8'h00) begin
            nd--;
        end
        nw = dividend_count;
        while (nw > 0 && dividend_coefs[nw - 1] == 8'h00) begin
            nw--;
        end
        dividend_count = 0;
        if (nd == 0) begin
            add_step_word('{gpd_pkg::KIND_DIV_ZERO, 8'h00, 1'b1});
            return;
        end
        for (int i = 0; i < COEFF_SLOTS; i++) begin
            quotient_coefs[i] = 8'h00;
        end
        inv = field_inv(divisor_coefs[nd - 1], poly_low);
        qn  = 0;
        if (nw >= nd) begin
            qn = nw - nd + 1;
            for (int pos = nw - 1; pos >= nd - 1; pos--) begin
                shift = pos - (nd - 1);
                t     = field_mul(dividend_coefs[pos], inv, poly_low);
                quotient_coefs[shift] = t;
                for (int j = 0; j < nd; j++) begin
                    dividend_coefs[shift + j] ^= field_mul(t, divisor_coefs[j], poly_low);
                end
                // The top term is cleared outright, even in a ring.
                dividend_coefs[pos] = 8'h00;
            end
        end
        while (qn > 0 && quotient_coefs[qn - 1] == 8'h00) begin
            qn--;
        end
        rn = (nw < nd) ? nw : nd - 1;
        while (rn > 0 && dividend_coefs[rn - 1] == 8'h00) begin
            rn--;
        end
        for (int i = 0; i < qn; i++) begin
            add_step_word('{gpd_pkg::KIND_QUOTIENT, quotient_coefs[i], 1'b0});
        end
        if (rn == 0) begin
            add_step_word('{gpd_pkg::KIND_REMAINDER, 8'h00, 1'b1});
        end else begin
            for (int i = 0; i < rn; i++) begin
                add_step_word('{gpd_pkg::KIND_REMAINDER, dividend_coefs[i], i == rn - 1});
            end
        end
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: MISMATCH %s", $time, msg);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // Monitor. Everything is sampled at the rising edge: accepted input words
    // feed the divider, accepted result words are checked against the oldest
    // prediction, and config writes update the divider's field polynomial.
    // A watchdog ends the run if no channel moves a word for too long.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        logic         moved;
        result_word_t want;
        if (aresetn) begin
            moved = 1'b0;
            if (cfg_valid && cfg_ready) begin
                poly_low = cfg_data;
                moved    = 1'b1;
            end
            if (s_tvalid && s_tready) begin
                divide_step(s_tuser[0], s_tdata, s_tlast);
                if (typed_valid) begin
                    add_expected_word(typed_word);
                end else begin
                    foreach (step_words[i]) begin
                        add_expected_word(step_words[i]);
                    end
                end
                moved = 1'b1;
            end
            if (m_tvalid && m_tready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch($sformatf("result word kind %0d data %02h with nothing expected",
                                              m_tuser, m_tdata));
                end else begin
                    want = expected_words.pop_front();
                    if (m_tuser !== want.kind) begin
                        report_mismatch($sformatf("kind: got %0d, expected %0d",
                                                  m_tuser, want.kind));
                    end
                    if (m_tdata !== want.coef) begin
                        report_mismatch($sformatf("coefficient: got %02h, expected %02h",
                                                  m_tdata, want.coef));
                    end
                    if (m_tlast !== want.last) begin
                        report_mismatch($sformatf("last: got %0b, expected %0b",
                                                  m_tlast, want.last));
                    end
                end
                moved = 1'b1;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // The receiver stalls at random, except during the quiet stretch.
    always @(negedge aclk) begin
        m_tready <= aresetn && (quiet || $urandom_range(99) >= IDLE_PERCENT);
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers. All inputs change at the falling edge only.
    // ------------------------------------------------------------------------

    // Coefficients lean toward the extremes so trimming and all-ones get hit.
    function automatic logic [7:0] pick_coef();
        int r;
        r = $urandom_range(99);
        if (r < 12) begin
            return 8'h00;
        end
        if (r < 20) begin
            return 8'hFF;
        end
        return 8'($urandom_range(255));
    endfunction

    // Sends one input word and returns at the falling edge after it is taken.
    // Valid only drops for a one-cycle gap, so it never drops and rises in one step.
    task automatic send_word(input logic cmd, input logic [7:0] coef, input logic last);
        quiet = (words_sent >= 90 && words_sent < 140);
        if (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tuser[0] <= cmd;
        s_tdata    <= coef;
        s_tlast    <= last;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        words_sent++;
        @(negedge aclk);
    endtask

    // Sends a whole polynomial. With zeros set, every coefficient is zero;
    // otherwise the top one is sometimes forced to zero to exercise trimming.
    task automatic send_poly(input logic cmd, input int len, input logic closed,
                             input logic zeros);
        logic [7:0] c;
        for (int i = 0; i < len; i++) begin
            c = zeros ? 8'h00 : pick_coef();
            if (i == len - 1 && !zeros && $urandom_range(99) < 20) begin
                c = 8'h00;
            end
            send_word(cmd, c, closed && i == len - 1);
        end
    endtask

    // Lets every predicted word come back, then a little more for the block
    // to settle, before a config write or the end of the run.
    task automatic drain();
        while (expected_words.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_field_poly(input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    stim_row_t  directed_rows [DIRECTED_ROWS];
    logic [7:0] phase_polys [5];

    initial begin : stimulus
        int pick;
        int phase_start;
        divider_reset();

        // Directed table, under the reset field polynomial. Typed words are
        // the ones that can be read off by eye: division by zero, a zero
        // remainder, and a dividend shorter than the divisor.
        directed_rows = '{
            // Nothing loaded since reset: the divisor is empty.
            '{gpd_pkg::CMD_DIVIDEND, 8'h55, 1'b1, 1'b1, '{gpd_pkg::KIND_DIV_ZERO, 8'h00, 1'b1}},
            // A divisor of zeros only trims down to nothing.
            '{gpd_pkg::CMD_DIVISOR,  8'h00, 1'b0, 1'b0, NO_WORD},
            '{gpd_pkg::CMD_DIVISOR,  8'h00, 1'b1, 1'b0, NO_WORD},
            '{gpd_pkg::CMD_DIVIDEND, 8'h12, 1'b1, 1'b1, '{gpd_pkg::KIND_DIV_ZERO, 8'h00, 1'b1}},
            // Start a new divisor but leave it open; the dividend uses it anyway.
            '{gpd_pkg::CMD_DIVISOR,  8'h03, 1'b0, 1'b0, NO_WORD},
            '{gpd_pkg::CMD_DIVIDEND, 8'h80, 1'b0, 1'b0, NO_WORD},
            '{gpd_pkg::CMD_DIVIDEND, 8'h01, 1'b1, 1'b0, NO_WORD},
            // The open divisor keeps growing: it is now 3 + x.
            '{gpd_pkg::CMD_DIVISOR,  8'h01, 1'b1, 1'b0, NO_WORD},
            // Zero dividend: no quotient and a single zero remainder.
            '{gpd_pkg::CMD_DIVIDEND, 8'h00, 1'b1, 1'b1, '{gpd_pkg::KIND_REMAINDER, 8'h00, 1'b1}},
            '{gpd_pkg::CMD_DIVIDEND, 8'hFF, 1'b0, 1'b0, NO_WORD},
            '{gpd_pkg::CMD_DIVIDEND, 8'h00, 1'b0, 1'b0, NO_WORD},
            '{gpd_pkg::CMD_DIVIDEND, 8'hAB, 1'b1, 1'b0, NO_WORD},
            // Dividend of lower degree: it comes back whole as the remainder.
            '{gpd_pkg::CMD_DIVIDEND, 8'h05, 1'b1, 1'b1, '{gpd_pkg::KIND_REMAINDER, 8'h05, 1'b1}},
            // A closed divisor is replaced by the next divisor word.
            '{gpd_pkg::CMD_DIVISOR,  8'hFF, 1'b1, 1'b0, NO_WORD},
            '{gpd_pkg::CMD_DIVIDEND, 8'h00, 1'b0, 1'b0, NO_WORD},
            '{gpd_pkg::CMD_DIVIDEND, 8'hFF, 1'b1, 1'b0, NO_WORD},
            // Divisor with a zero top coefficient trims to the constant 1.
            '{gpd_pkg::CMD_DIVISOR,  8'h01, 1'b0, 1'b0, NO_WORD},
            '{gpd_pkg::CMD_DIVISOR,  8'h00, 1'b1, 1'b0, NO_WORD},
            '{gpd_pkg::CMD_DIVIDEND, 8'hFF, 1'b1, 1'b0, NO_WORD},
            // All-zero dividend of several words.
            '{gpd_pkg::CMD_DIVIDEND, 8'h00, 1'b0, 1'b0, NO_WORD},
            '{gpd_pkg::CMD_DIVIDEND, 8'h00, 1'b0, 1'b0, NO_WORD},
            '{gpd_pkg::CMD_DIVIDEND, 8'h00, 1'b1, 1'b1, '{gpd_pkg::KIND_REMAINDER, 8'h00, 1'b1}},
            '{gpd_pkg::CMD_DIVISOR,  8'h80, 1'b0, 1'b0, NO_WORD},
            '{gpd_pkg::CMD_DIVISOR,  8'h7F, 1'b1, 1'b0, NO_WORD},
            '{gpd_pkg::CMD_DIVIDEND, 8'hFF, 1'b1, 1'b1, '{gpd_pkg::KIND_REMAINDER, 8'hFF, 1'b1}}
        };
        phase_polys = '{8'h00, 8'hFF, 8'($urandom_range(255)), 8'h1D,
                        gpd_pkg::FIELD_POLY_RST};

        // Synchronous reset, released on a falling edge.
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i]) begin
            typed_valid = directed_rows[i].typed;
            typed_word  = directed_rows[i].want;
            send_word(directed_rows[i].cmd, directed_rows[i].coef, directed_rows[i].last);
        end
        typed_valid = 1'b0;

        // Random part, one phase per field polynomial. The zero and all-ones
        // polynomials are reducible, so those phases run the ring behavior.
        foreach (phase_polys[p]) begin
            s_tvalid <= 1'b0;
            drain();
            write_field_poly(phase_polys[p]);
            if (p == 1) begin
                // Overfill both stores: the 33rd word is dropped, its last still acts.
                send_poly(gpd_pkg::CMD_DIVISOR, COEFF_SLOTS + 1, 1'b1, 1'b0);
                send_poly(gpd_pkg::CMD_DIVIDEND, COEFF_SLOTS + 1, 1'b1, 1'b0);
            end
            phase_start = words_sent;
            for (int n = 0; n < PHASE_WORDS; ) begin
                pick = $urandom_range(99);
                if (pick < 68) begin
                    // Well-formed: maybe a new divisor, then a few dividends.
                    if ($urandom_range(2) == 0 || n == 0) begin
                        send_poly(gpd_pkg::CMD_DIVISOR, $urandom_range(1, 5), 1'b1, 1'b0);
                    end
                    repeat ($urandom_range(1, 3)) begin
                        send_poly(gpd_pkg::CMD_DIVIDEND, $urandom_range(1, 8), 1'b1, 1'b0);
                    end
                end else if (pick < 78) begin
                    // Divisor left open while a dividend is divided.
                    send_poly(gpd_pkg::CMD_DIVISOR, $urandom_range(1, 3), 1'b0, 1'b0);
                    send_poly(gpd_pkg::CMD_DIVIDEND, $urandom_range(1, 6), 1'b1, 1'b0);
                end else if (pick < 86) begin
                    // Dividend split over several sequences.
                    send_poly(gpd_pkg::CMD_DIVIDEND, $urandom_range(1, 4), 1'b0, 1'b0);
                end else if (pick < 93) begin
                    send_poly(gpd_pkg::CMD_DIVISOR, $urandom_range(1, 3), 1'b1, 1'b1);
                end else begin
                    // Stray word with random command and last.
                    send_word(1'($urandom_range(1)), pick_coef(), 1'($urandom_range(1)));
                end
                n = words_sent - phase_start;
            end
        end

        s_tvalid <= 1'b0;
        drain();
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/gpd_pkg.sv
rtl/gpd_ram.sv
rtl/gf256_poly_divide_top.sv
rtl/gpd_checker.sv
test/tb_top.sv
